// ===== rtl/core/fbsa_pkg.sv =====
// Shared types, constants and helpers of the fixed-block segment allocator.
package fbsa_pkg;

    // Sizing of the allocator.
    localparam int SEGMENTS    = 4;
    localparam int STACK_DEPTH = 256;

    // Derived widths of the free-stack storage.
    localparam int STK_IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int STK_ADDR_W = (SEGMENTS * STACK_DEPTH > 1) ?
                                $clog2(SEGMENTS * STACK_DEPTH) : 1;

    // Fixed widths of the address space and of the fields.
    localparam int LIN_W     = 21;
    localparam int SPAN_W    = 19;
    localparam int SEG_W     = 2;
    localparam int DATA_W    = 16;
    localparam int OFS_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_SEGS  = 4;

    // Address map constants.
    localparam logic [SPAN_W-1:0] BANK_SPAN  = 19'h02000;
    localparam logic [2:0]        WINDOW_TOP = 3'b101;
    localparam logic [DATA_W-1:0] COUNT_MAX  = 16'hFFFF;

    // Configuration register selector: the low index bit picks the register of a segment.
    localparam logic CFG_SEL_BLK_SIZE = 1'b0;
    localparam logic CFG_SEL_BYTES    = 1'b1;

    // Commands.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOFIT     = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Request word.
    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] request_size;
        logic [7:0]        free_bank;
        logic [DATA_W-1:0] free_window_address;
    } t_req;

    // Result word.
    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        block_bank;
        logic [DATA_W-1:0] block_window_address;
        logic [SEG_W-1:0]  segment_index;
        logic [DATA_W-1:0] use_count;
        logic [DATA_W-1:0] use_peak;
    } t_rsp;

    // Free-stack memory address of one entry of one segment's stack.
    function automatic logic [STK_ADDR_W-1:0] stk_addr(input logic [SEG_W-1:0] seg,
                                                       input logic [STK_IDX_W-1:0] idx);
        logic [31:0] addr;
        addr = 32'(seg) * 32'(STACK_DEPTH) + 32'(idx);
        return addr[STK_ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/fbsa_if.sv =====
// Request and result channel interfaces of the fixed-block segment allocator.
interface fbsa_req_if;
    logic          valid;
    logic          ready;
    fbsa_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fbsa_rsp_if;
    logic          valid;
    logic          ready;
    fbsa_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fbsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module fbsa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fixed_block_segment_allocator_unit.sv =====
// Top level of the fixed-block segment allocator.
//
// The block hands out and takes back fixed-size blocks from up to four segments
// of banked RAM, laid out one after another from bank 1, window 0xA000.
// Requests arrive on i_req (valid/ready); each word carries an allocate or a
// free command. Every request gives exactly one result word on o_rsp, with a
// status, the block's bank and window address, and the segment's use counts.
// Segments are set up through the write port i_cfg_we/i_cfg_index/i_cfg_data;
// any register write returns every segment to its empty state, so write the
// registers only while no request is in flight.
// Accepting a request issues the read of the segment's free stack from memory;
// in the execute state, the block modifies, writes back and
// registers the result word for o_rsp. No new request is taken until the
// current one is done. The result register lets the next request be accepted
// while a result still waits; if the receiver holds ready low, the block
// finishes its current request only once the result register is free. After
// reset all segments are unused and every count is zero; the free-stack
// memory needs no clearing pass.
module fixed_block_segment_allocator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    fbsa_req_if.sink                           i_req,
    fbsa_rsp_if.source                         o_rsp,
    input  logic                               i_cfg_we,
    input  logic [fbsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbsa_pkg::DATA_W-1:0]        i_cfg_data
);

    localparam int SEGMENTS   = fbsa_pkg::SEGMENTS;
    localparam int LIN_W      = fbsa_pkg::LIN_W;
    localparam int SPAN_W     = fbsa_pkg::SPAN_W;
    localparam int SEG_W      = fbsa_pkg::SEG_W;
    localparam int DATA_W     = fbsa_pkg::DATA_W;
    localparam int OFS_W      = fbsa_pkg::OFS_W;
    localparam int STK_IDX_W  = fbsa_pkg::STK_IDX_W;
    localparam int STK_CNT_W  = fbsa_pkg::STK_CNT_W;
    localparam int STK_ADDR_W = fbsa_pkg::STK_ADDR_W;
    localparam int CFG_IDX_TOP = fbsa_pkg::CFG_IDX_W - 1;

    // Sequencer states.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // Configuration registers.
    logic [DATA_W-1:0] r_blk_size  [fbsa_pkg::CFG_SEGS];
    logic [DATA_W-1:0] r_seg_bytes [fbsa_pkg::CFG_SEGS];

    // Per-segment state.
    logic [DATA_W-1:0]    r_pool_off [SEGMENTS];
    logic [STK_CNT_W-1:0] r_stk_cnt  [SEGMENTS];
    logic [DATA_W-1:0]    r_use      [SEGMENTS];
    logic [DATA_W-1:0]    r_peak     [SEGMENTS];

    // Request held during the read-modify-write.
    logic                 r_state;
    logic                 r_cmd;
    logic                 r_hit;
    logic [SEG_W-1:0]     r_seg;
    logic [STK_CNT_W-1:0] r_cnt;
    logic [LIN_W-1:0]     r_lin;

    // Result register.
    logic           r_ovalid;
    fbsa_pkg::t_rsp r_rsp;

    // Segment layout.
    logic [SPAN_W-1:0] w_floor [SEGMENTS];
    logic [SPAN_W-1:0] w_ceil  [SEGMENTS];
    logic              w_used  [SEGMENTS];

    // Request decode.
    logic                 w_accept;
    logic [LIN_W-1:0]     w_free_lin;
    logic [SEG_W-1:0]     w_sel;
    logic                 w_hit;
    logic [STK_IDX_W-1:0] w_rd_idx;

    // Read-modify-write results.
    logic                 w_commit;
    logic                 w_upd;
    logic                 w_push;
    logic [DATA_W-1:0]    w_new_off;
    logic [STK_CNT_W-1:0] w_new_cnt;
    logic [DATA_W-1:0]    w_new_use;
    logic [DATA_W-1:0]    w_new_peak;
    fbsa_pkg::t_rsp       w_rsp;
    logic [LIN_W-1:0]     w_ram_rdata;

    // Segment floors and ceilings: each used segment starts where the last used one ends.
    always_comb begin
        logic [SPAN_W-1:0] acc;
        acc = fbsa_pkg::BANK_SPAN;
        for (int s = 0; s < SEGMENTS; s++) begin
            w_used[s]  = (r_blk_size[s] != '0);
            w_floor[s] = acc;
            w_ceil[s]  = acc + SPAN_W'(r_seg_bytes[s]);
            if (w_used[s]) begin
                acc = w_ceil[s];
            end
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // Choose the segment: first fit for an allocate, owning range for a free.
    always_comb begin
        logic win_ok;
        win_ok     = (i_req.data.free_window_address[DATA_W-1:OFS_W] == fbsa_pkg::WINDOW_TOP);
        w_free_lin = {i_req.data.free_bank, i_req.data.free_window_address[OFS_W-1:0]};
        w_sel      = '0;
        w_hit      = 1'b0;
        for (int s = SEGMENTS - 1; s >= 0; s--) begin
            if (i_req.data.command == fbsa_pkg::CMD_ALLOC) begin
                if (w_used[s] && (r_blk_size[s] >= i_req.data.request_size)) begin
                    w_sel = SEG_W'(s);
                    w_hit = 1'b1;
                end
            end else begin
                if (win_ok && w_used[s] && (w_free_lin >= LIN_W'(w_floor[s]))
                        && (w_free_lin < LIN_W'(w_ceil[s]))) begin
                    w_sel = SEG_W'(s);
                    w_hit = 1'b1;
                end
            end
        end
    end

    // Top of stack of the chosen segment, for a pop.
    always_comb begin
        logic [STK_CNT_W-1:0] top;
        top = r_stk_cnt[w_sel] - STK_CNT_W'(1);
        if (r_stk_cnt[w_sel] == '0) begin
            w_rd_idx = '0;
        end else begin
            w_rd_idx = top[STK_IDX_W-1:0];
        end
    end

    // Free-stack memory of all segments.
    fbsa_ram #(
        .WIDTH (LIN_W),
        .DEPTH (SEGMENTS * fbsa_pkg::STACK_DEPTH),
        .ADDR_W(STK_ADDR_W)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (w_commit && w_push),
        .i_waddr(fbsa_pkg::stk_addr(r_seg, r_cnt[STK_IDX_W-1:0])),
        .i_wdata(r_lin),
        .i_re   (w_accept),
        .i_raddr(fbsa_pkg::stk_addr(w_sel, w_rd_idx)),
        .o_rdata(w_ram_rdata)
    );

    // Modify step: pop or bump on allocate, push on free, and form the result word.
    always_comb begin
        logic [DATA_W:0]    pool_end;
        logic [LIN_W-1:0]   lin;
        logic               got;
        logic [DATA_W-1:0]  cur_bs;
        logic [DATA_W-1:0]  cur_bytes;
        logic [DATA_W-1:0]  cur_off;
        logic [DATA_W-1:0]  cur_use;
        logic [DATA_W-1:0]  cur_peak;
        cur_bs     = r_blk_size[r_seg];
        cur_bytes  = r_seg_bytes[r_seg];
        cur_off    = r_pool_off[r_seg];
        cur_use    = r_use[r_seg];
        cur_peak   = r_peak[r_seg];
        pool_end   = {1'b0, cur_off} + {1'b0, cur_bs};
        lin        = '0;
        got        = 1'b0;
        w_upd      = 1'b0;
        w_push     = 1'b0;
        w_new_off  = cur_off;
        w_new_cnt  = r_cnt;
        w_new_use  = cur_use;
        w_new_peak = cur_peak;
        w_rsp      = '0;
        if (r_cmd == fbsa_pkg::CMD_ALLOC) begin
            if (!r_hit) begin
                w_rsp.status = fbsa_pkg::ST_NOFIT;
            end else begin
                if (r_cnt != '0) begin
                    got       = 1'b1;
                    lin       = w_ram_rdata;
                    w_new_cnt = r_cnt - STK_CNT_W'(1);
                end else if (pool_end <= {1'b0, cur_bytes}) begin
                    got       = 1'b1;
                    lin       = LIN_W'(w_floor[r_seg]) + LIN_W'(cur_off);
                    w_new_off = pool_end[DATA_W-1:0];
                end
                if (got) begin
                    w_upd = 1'b1;
                    if (cur_use != fbsa_pkg::COUNT_MAX) begin
                        w_new_use = cur_use + DATA_W'(1);
                    end
                    if (w_new_use > cur_peak) begin
                        w_new_peak = w_new_use;
                    end
                    w_rsp.status               = fbsa_pkg::ST_OK;
                    w_rsp.block_bank           = lin[LIN_W-1:OFS_W];
                    w_rsp.block_window_address = {fbsa_pkg::WINDOW_TOP, lin[OFS_W-1:0]};
                end else begin
                    w_rsp.status = fbsa_pkg::ST_EXHAUSTED;
                end
                w_rsp.segment_index = r_seg;
                w_rsp.use_count     = w_new_use;
                w_rsp.use_peak      = w_new_peak;
            end
        end else begin
            if (!r_hit) begin
                w_rsp.status = fbsa_pkg::ST_OUTSIDE;
            end else begin
                if (r_cnt >= STK_CNT_W'(fbsa_pkg::STACK_DEPTH)) begin
                    w_rsp.status = fbsa_pkg::ST_FULL;
                end else begin
                    w_upd     = 1'b1;
                    w_push    = 1'b1;
                    w_new_cnt = r_cnt + STK_CNT_W'(1);
                    if (cur_use != '0) begin
                        w_new_use = cur_use - DATA_W'(1);
                    end
                    w_rsp.status = fbsa_pkg::ST_OK;
                end
                w_rsp.segment_index = r_seg;
                w_rsp.use_count     = w_new_use;
                w_rsp.use_peak      = w_new_peak;
            end
        end
    end

    // The request finishes once the result register can take its word.
    assign w_commit = (r_state == S_EXEC) && (!r_ovalid || o_rsp.ready);

    // Sequencer and captured request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_req.data.command;
            r_hit <= w_hit;
            r_seg <= w_sel;
            r_cnt <= r_stk_cnt[w_sel];
            r_lin <= w_free_lin;
        end
    end

    // Configuration registers and per-segment state; a register write empties every segment.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < fbsa_pkg::CFG_SEGS; s++) begin
                r_blk_size[s]  <= '0;
                r_seg_bytes[s] <= '0;
            end
            for (int s = 0; s < SEGMENTS; s++) begin
                r_pool_off[s] <= '0;
                r_stk_cnt[s]  <= '0;
                r_use[s]      <= '0;
                r_peak[s]     <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index[0] == fbsa_pkg::CFG_SEL_BYTES) begin
                r_seg_bytes[i_cfg_index[CFG_IDX_TOP:1]] <= i_cfg_data;
            end else begin
                r_blk_size[i_cfg_index[CFG_IDX_TOP:1]] <= i_cfg_data;
            end
            for (int s = 0; s < SEGMENTS; s++) begin
                r_pool_off[s] <= '0;
                r_stk_cnt[s]  <= '0;
                r_use[s]      <= '0;
                r_peak[s]     <= '0;
            end
        end else if (w_commit && w_upd) begin
            r_pool_off[r_seg] <= w_new_off;
            r_stk_cnt[r_seg]  <= w_new_cnt;
            r_use[r_seg]      <= w_new_use;
            r_peak[r_seg]     <= w_new_peak;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_commit) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

endmodule

// ===== tb/fixed_block_segment_allocator_unit_tb.sv =====
// Self-checking testbench of the fixed-block segment allocator with its own allocation model.
module fixed_block_segment_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbsa_pkg::*;

    // Address map of the banked window.
    localparam logic [15:0] WINDOW_BASE = 16'hA000;
    localparam logic [15:0] WINDOW_END  = 16'hC000;
    localparam logic [21:0] FIRST_FLOOR = 22'h002000;

    // Idling profiles, one per phase.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam int RANDOM_PHASES    = 8;
    localparam int WORDS_PER_PHASE  = 70;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [DATA_W-1:0]     i_cfg_data;

    fbsa_req_if req_if ();
    fbsa_rsp_if rsp_if ();

    fixed_block_segment_allocator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Request words waiting to be driven and result words still owed by the block.
    t_req request_backlog [$];
    t_rsp awaited_results [$];
    int   mismatch_count    = 0;
    int   sender_idle_pct   = 0;
    int   receiver_stall_pct = 0;

    // Model copy of the configuration registers and of the per-segment state.
    bit [DATA_W-1:0] seg_regs     [2*CFG_SEGS];
    bit [21:0]       pool_ptr     [SEGMENTS];
    bit [LIN_W-1:0]  stack_mem    [SEGMENTS][STACK_DEPTH];
    int unsigned     stack_fill   [SEGMENTS];
    bit [DATA_W-1:0] in_use       [SEGMENTS];
    bit [DATA_W-1:0] in_use_peak  [SEGMENTS];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit [DATA_W-1:0] seg_block(input int s);
        logic [SEG_W-1:0] code;
        code = s[SEG_W-1:0];
        return seg_regs[{code, CFG_SEL_BLK_SIZE}];
    endfunction

    function automatic bit [DATA_W-1:0] seg_bytes(input int s);
        logic [SEG_W-1:0] code;
        code = s[SEG_W-1:0];
        return seg_regs[{code, CFG_SEL_BYTES}];
    endfunction

    // Segments are packed one after another; unused ones take no space.
    function automatic bit [21:0] seg_floor(input int s);
        bit [21:0] lin;
        lin = FIRST_FLOOR;
        for (int t = 0; t < s; t++) begin
            if (seg_block(t) != 0) begin
                lin += seg_bytes(t);
            end
        end
        return lin;
    endfunction

    function automatic bit [21:0] seg_ceiling(input int s);
        return seg_floor(s) + seg_bytes(s);
    endfunction

    // Any register write empties every segment and moves the pools to the new floors.
    function automatic void apply_register_write(input int idx, input bit [DATA_W-1:0] value);
        seg_regs[idx] = value;
        for (int s = 0; s < SEGMENTS; s++) begin
            pool_ptr[s]    = seg_floor(s);
            stack_fill[s]  = 0;
            in_use[s]      = '0;
            in_use_peak[s] = '0;
        end
    endfunction

    // Works out the result word of one request and updates the model state.
    function automatic t_rsp predict_allocation(input t_req rq);
        t_rsp           r;
        int             hit;
        bit             got;
        bit [LIN_W-1:0] lin;
        r   = '0;
        hit = -1;
        got = 1'b0;
        lin = '0;
        if (rq.command == CMD_ALLOC) begin
            // First fit over the used segments.
            for (int t = 0; t < SEGMENTS; t++) begin
                if (hit < 0 && seg_block(t) != 0 && seg_block(t) >= rq.request_size) begin
                    hit = t;
                end
            end
            if (hit < 0) begin
                r.status = ST_NOFIT;
            end else begin
                // Recycled blocks go out before fresh ones from the pool.
                if (stack_fill[hit] > 0) begin
                    stack_fill[hit]--;
                    lin = stack_mem[hit][stack_fill[hit]];
                    got = 1'b1;
                end else if (pool_ptr[hit] + seg_block(hit) <= seg_ceiling(hit)) begin
                    lin           = pool_ptr[hit][LIN_W-1:0];
                    pool_ptr[hit] += seg_block(hit);
                    got           = 1'b1;
                end
                if (got) begin
                    if (in_use[hit] != COUNT_MAX) begin
                        in_use[hit]++;
                    end
                    if (in_use[hit] > in_use_peak[hit]) begin
                        in_use_peak[hit] = in_use[hit];
                    end
                    r.block_bank           = lin[20:13];
                    r.block_window_address = WINDOW_BASE | {3'b000, lin[12:0]};
                end else begin
                    r.status = ST_EXHAUSTED;
                end
                r.segment_index = hit[SEG_W-1:0];
                r.use_count     = in_use[hit];
                r.use_peak      = in_use_peak[hit];
            end
        end else begin
            if (rq.free_window_address < WINDOW_BASE || rq.free_window_address >= WINDOW_END) begin
                r.status = ST_OUTSIDE;
            end else begin
                lin = {rq.free_bank, rq.free_window_address[12:0]};
                for (int t = 0; t < SEGMENTS; t++) begin
                    if (hit < 0 && seg_block(t) != 0 && {1'b0, lin} >= seg_floor(t)
                        && {1'b0, lin} < seg_ceiling(t)) begin
                        hit = t;
                    end
                end
                if (hit < 0) begin
                    r.status = ST_OUTSIDE;
                end else begin
                    if (stack_fill[hit] >= STACK_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        stack_mem[hit][stack_fill[hit]] = lin;
                        stack_fill[hit]++;
                        if (in_use[hit] != 0) begin
                            in_use[hit]--;
                        end
                    end
                    r.segment_index = hit[SEG_W-1:0];
                    r.use_count     = in_use[hit];
                    r.use_peak      = in_use_peak[hit];
                end
            end
        end
        return r;
    endfunction

    // Request builders; the fields that the command does not use carry random bits.
    function automatic t_req alloc_word(input bit [DATA_W-1:0] size);
        t_req w;
        w.command             = CMD_ALLOC;
        w.request_size        = size;
        w.free_bank           = 8'($urandom_range(255));
        w.free_window_address = 16'($urandom_range(16'hFFFF));
        return w;
    endfunction

    function automatic t_req free_word(input bit [7:0] bank, input bit [15:0] window);
        t_req w;
        w.command             = CMD_FREE;
        w.request_size        = 16'($urandom_range(16'hFFFF));
        w.free_bank           = bank;
        w.free_window_address = window;
        return w;
    endfunction

    // Mostly well-formed traffic aimed at the live segments, with some noise.
    function automatic t_req random_word();
        t_req        w;
        int          used [$];
        int          pick;
        int          s;
        int unsigned cap;
        bit [21:0]   lin;
        pick = $urandom_range(99);
        for (int t = 0; t < SEGMENTS; t++) begin
            if (seg_block(t) != 0) begin
                used.push_back(t);
            end
        end
        if (used.size() == 0 || pick >= 90) begin
            w = free_word(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)));
            if ($urandom_range(1) == 0) begin
                w.free_window_address = 16'($urandom_range(WINDOW_BASE, WINDOW_END - 1));
            end
            if ($urandom_range(1) == 0) begin
                w.command = CMD_ALLOC;
            end
            return w;
        end
        s = used[$urandom_range(used.size() - 1)];
        if (pick < 55) begin
            if ($urandom_range(9) == 0) begin
                return alloc_word(16'($urandom_range(16'hFFFF)));
            end
            return alloc_word(16'($urandom_range(seg_block(s))));
        end
        // Free of an aligned block, usually one the pool has already handed out.
        cap = 32'(seg_bytes(s) / seg_block(s));
        if ($urandom_range(3) != 0
                && 32'((pool_ptr[s] - seg_floor(s)) / seg_block(s)) < cap) begin
            cap = 32'((pool_ptr[s] - seg_floor(s)) / seg_block(s));
        end
        lin = seg_floor(s) + 22'($urandom_range(cap) * seg_block(s));
        return free_word(lin[20:13], {3'b101, lin[12:0]});
    endfunction

    function automatic void set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct    = 68;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 68;
            end
            default: begin
                sender_idle_pct    = 37;
                receiver_stall_pct = 37;
            end
        endcase
    endfunction

    // Waits until every request has been taken and answered, then lets the pipeline settle.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (request_backlog.size() != 0 || req_if.valid || awaited_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes both registers of every segment; the block must be idle.
    task automatic load_layout(input bit [DATA_W-1:0] blk [SEGMENTS],
                               input bit [DATA_W-1:0] bytes [SEGMENTS]);
        logic [SEG_W-1:0] code;
        for (int s = 0; s < SEGMENTS; s++) begin
            code = s[SEG_W-1:0];
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= {code, CFG_SEL_BLK_SIZE};
            i_cfg_data  <= blk[s];
            apply_register_write({code, CFG_SEL_BLK_SIZE}, blk[s]);
            @(posedge i_clk);
            i_cfg_index <= {code, CFG_SEL_BYTES};
            i_cfg_data  <= bytes[s];
            apply_register_write({code, CFG_SEL_BYTES}, bytes[s]);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random segment layout, mostly with block sizes growing from segment to segment.
    task automatic draw_layout(output bit [DATA_W-1:0] blk [SEGMENTS],
                               output bit [DATA_W-1:0] bytes [SEGMENTS]);
        int unsigned total;
        for (int s = 0; s < SEGMENTS; s++) begin
            if ($urandom_range(4) == 0) begin
                blk[s] = '0;
            end else if ($urandom_range(9) == 0) begin
                blk[s] = 16'($urandom_range(16'hFFFF, 1));
            end else begin
                blk[s] = 16'($urandom_range(32, 1) << (2 * s));
            end
            total = blk[s] * $urandom_range(12);
            if ($urandom_range(9) == 0) begin
                total = $urandom_range(16'hFFFF);
            end
            bytes[s] = (total > 16'hFFFF) ? 16'hFFFF : 16'(total);
        end
    endtask

    // Request driver: presents the next word once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                awaited_results.push_back(predict_allocation(req_if.data));
            end
            if (!req_if.valid || req_if.ready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= request_backlog.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Result monitor: compares each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with no request outstanding: %h", rsp_if.data);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, rsp_if.data.status);
                    check_field("block_bank", want.block_bank, rsp_if.data.block_bank);
                    check_field("block_window_address", want.block_window_address,
                                rsp_if.data.block_window_address);
                    check_field("segment_index", want.segment_index,
                                rsp_if.data.segment_index);
                    check_field("use_count", want.use_count,
                                rsp_if.data.use_count);
                    check_field("use_peak", want.use_peak,
                                rsp_if.data.use_peak);
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Stimulus sequence.
    initial begin
        bit [DATA_W-1:0] layout_blk   [SEGMENTS];
        bit [DATA_W-1:0] layout_bytes [SEGMENTS];
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        for (int r = 0; r < 2 * CFG_SEGS; r++) begin
            apply_register_write(r, '0);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_idle_mode(IDLE_NONE);

        // Straight after reset no segment is in use.
        request_backlog.push_back(alloc_word(16'hFFFF));
        request_backlog.push_back(alloc_word(16'h0000));
        request_backlog.push_back(free_word(8'd1, WINDOW_BASE));
        wait_drained();

        // Directed layout: a small segment, an unused one, a bank-sized one and a maximal one.
        layout_blk   = '{16'd16, 16'd0, 16'h2000, 16'hFFFF};
        layout_bytes = '{16'd48, 16'h1234, 16'h4000, 16'hFFFF};
        load_layout(layout_blk, layout_bytes);
        request_backlog.push_back(alloc_word(16'd0));
        request_backlog.push_back(alloc_word(16'd16));
        request_backlog.push_back(alloc_word(16'd17));
        request_backlog.push_back(alloc_word(16'hFFFF));
        request_backlog.push_back(alloc_word(16'hFFFF));
        request_backlog.push_back(alloc_word(16'd1));
        request_backlog.push_back(alloc_word(16'd1));
        request_backlog.push_back(free_word(8'd1, 16'hA010));
        request_backlog.push_back(alloc_word(16'd5));
        request_backlog.push_back(free_word(8'd1, 16'h9FFF));
        request_backlog.push_back(free_word(8'd1, WINDOW_END));
        request_backlog.push_back(free_word(8'd255, 16'hFFFF));
        request_backlog.push_back(free_word(8'd0, 16'h0000));
        request_backlog.push_back(free_word(8'd0, 16'hBFFF));
        request_backlog.push_back(free_word(8'd255, 16'hBFFF));
        // Misaligned free inside a segment, and the last byte of the first segment.
        request_backlog.push_back(free_word(8'd1, 16'hA033));
        request_backlog.push_back(free_word(8'd1, 16'hA02F));
        // Frees of the largest segment's one live block, the last two at a use count of zero.
        request_backlog.push_back(free_word(8'd3, 16'hA030));
        request_backlog.push_back(free_word(8'd3, 16'hA030));
        request_backlog.push_back(free_word(8'd3, 16'hA030));
        wait_drained();

        // Random phases over fixed extreme layouts and drawn ones.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    layout_blk   = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                    layout_bytes = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                end
                1: begin
                    layout_blk   = '{16'd1, 16'd2, 16'd3, 16'd4};
                    layout_bytes = '{16'd4, 16'd0, 16'd9, 16'hFFFF};
                end
                2: begin
                    layout_blk   = '{16'd0, 16'd8, 16'd0, 16'h2000};
                    layout_bytes = '{16'hFFFF, 16'd64, 16'd0, 16'h6000};
                end
                default: begin
                    draw_layout(layout_blk, layout_bytes);
                end
            endcase
            load_layout(layout_blk, layout_bytes);
            set_idle_mode(t_idle_mode'(phase % 4));
            // Words are made one at a time so that frees follow the live pools.
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                while (request_backlog.size() >= 2) begin
                    @(negedge i_clk);
                end
                request_backlog.push_back(random_word());
            end
            wait_drained();
        end

        // Deep run on one small segment of one-byte blocks: fill the free stack past its
        // depth, then allocate until the stack is empty, the pool is used up and the
        // segment is exhausted.
        layout_blk   = '{16'd1, 16'd0, 16'd0, 16'd0};
        layout_bytes = '{16'd16, 16'd0, 16'd0, 16'd0};
        load_layout(layout_blk, layout_bytes);
        set_idle_mode(IDLE_NONE);
        repeat (STACK_DEPTH + 1) request_backlog.push_back(free_word(8'd1, WINDOW_BASE));
        repeat (STACK_DEPTH + 17) request_backlog.push_back(alloc_word(16'd1));
        wait_drained();

        if (mismatch_count == 0) begin
            $display("[fixed_block_segment_allocator_unit] OK");
        end else begin
            $display("[fixed_block_segment_allocator_unit] ERROR");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #10ms;
        $display("[fixed_block_segment_allocator_unit] ERROR");
        $finish;
    end

endmodule

// ===== fixed_block_segment_allocator_unit.f =====
rtl/core/fbsa_pkg.sv
rtl/core/fbsa_if.sv
rtl/core/fbsa_ram.sv
rtl/core/fixed_block_segment_allocator_unit.sv
tb/fixed_block_segment_allocator_unit_tb.sv
